// ----- sv/mbt_pkg.sv -----
`default_nettype none

package mbt_pkg;

  // Default build widths
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int ITER_BITS_DEF  = 15;

  // Register file geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int EDGE_W     = 32;
  localparam int STEP_W     = 31;

  // Register reset values: -2.0, -1.125, 0.003125, 0.003125 in Q4.28, limit 256
  localparam logic [EDGE_W-1:0] LEFT_EDGE_RST = 32'hE000_0000;
  localparam logic [EDGE_W-1:0] TOP_EDGE_RST  = 32'hEE00_0000;
  localparam logic [STEP_W-1:0] STEP_X_RST    = 31'd838861;
  localparam logic [STEP_W-1:0] STEP_Y_RST    = 31'd838861;
  localparam int                MAX_ITER_RST  = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_EDGE = 3'd0,
    CFG_TOP_EDGE  = 3'd1,
    CFG_STEP_X    = 3'd2,
    CFG_STEP_Y    = 3'd3,
    CFG_MAX_ITER  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CINIT,
    ST_CHECK,
    ST_MUL,
    ST_SUM,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic init_c;
    logic mul_go;
    logic sum;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic too_big;
    logic mul_done;
    logic escaped;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/mbt_mul.sv -----
`default_nettype none

module mbt_mul #(
  parameter int MW = mbt_pkg::FRAC_BITS_DEF + 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            go_i,
  input  wire logic [MW-1:0]   a_i,
  input  wire logic [MW-1:0]   b_i,
  output logic                 done_o,
  output logic [2*MW-1:0]      p_o
);

  // Operands are cut into chunks of at most 32 bits; one chunk product per cycle
  localparam int NCH  = (MW + 31) / 32;
  localparam int CHW  = (MW + NCH - 1) / NCH;
  localparam int PADW = NCH * CHW;
  localparam int AW   = 2 * PADW;
  localparam int IW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PSW  = $clog2(2 * NCH);

  logic [PADW-1:0]  a_q, b_q;
  logic [IW-1:0]    ia_q, ib_q;
  logic             issue_q, ppv_q, last_q, done_q;
  logic [2*CHW-1:0] pp_q;
  logic [PSW-1:0]   psh_q;
  logic [AW-1:0]    acc_q;

  logic [CHW-1:0]   a_chunk, b_chunk;
  logic             ib_last, ia_last;

  assign a_chunk = a_q[ia_q*CHW +: CHW];
  assign b_chunk = b_q[ib_q*CHW +: CHW];
  assign ib_last = (ib_q == IW'(NCH - 1));
  assign ia_last = (ia_q == IW'(NCH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      ppv_q   <= 1'b0;
      done_q  <= 1'b0;
      ia_q    <= '0;
      ib_q    <= '0;
    end else begin
      ppv_q  <= issue_q;
      done_q <= ppv_q && last_q;
      if (go_i) begin
        issue_q <= 1'b1;
        ia_q    <= '0;
        ib_q    <= '0;
      end else if (issue_q) begin
        if (ib_last) begin
          ib_q <= '0;
          ia_q <= ia_q + 1'b1;
          if (ia_last) begin
            issue_q <= 1'b0;
          end
        end else begin
          ib_q <= ib_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= PADW'(a_i);
      b_q   <= PADW'(b_i);
      acc_q <= '0;
    end else if (ppv_q) begin
      acc_q <= acc_q + (AW'(pp_q) << (psh_q * CHW));
    end
    if (issue_q) begin
      pp_q   <= a_chunk * b_chunk;
      psh_q  <= PSW'(ia_q) + PSW'(ib_q);
      last_q <= ia_last && ib_last;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q[2*MW-1:0];

`ifndef ASSERT_OFF
  a_done_after_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !issue_q && !ppv_q)
    else $error("multiplier finished while partial products were pending");
`endif

endmodule

`default_nettype wire

// ----- sv/mbt_datapath.sv -----
`default_nettype none

module mbt_datapath #(
  parameter int COORD_BITS = mbt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mbt_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS  = mbt_pkg::ITER_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mbt_pkg::cmd_t                  cmd_i,
  output mbt_pkg::stat_t                      stat_o,
  input  wire logic [COORD_BITS-1:0]          column_i,
  input  wire logic [COORD_BITS-1:0]          row_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [mbt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mbt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [ITER_BITS-1:0]                count_o
);

  localparam int MW     = FRAC_BITS + 1;
  localparam int PW     = 2 * MW;
  localparam int PROD_W = COORD_BITS + mbt_pkg::STEP_W;
  localparam int CW_RAW = (PROD_W > mbt_pkg::EDGE_W) ? PROD_W : mbt_pkg::EDGE_W;
  localparam int CCW    = CW_RAW + 1;
  localparam int ZW_RAW = (FRAC_BITS + 3 > CCW) ? FRAC_BITS + 3 : CCW;
  localparam int ZW     = ZW_RAW + 1;
  localparam int DW     = PW + 1;
  localparam int XW     = PW + 2;

  logic signed [mbt_pkg::EDGE_W-1:0] left_edge_q, top_edge_q;
  logic [mbt_pkg::STEP_W-1:0]        step_x_q, step_y_q;
  logic [ITER_BITS-1:0]              max_iter_q;

  logic [PROD_W-1:0]    cprod_r_q, cprod_i_q;
  logic signed [CCW-1:0] cr_q, ci_q;
  logic signed [ZW-1:0]  zr_q, zi_q;
  logic [ITER_BITS-1:0]  n_q;
  logic signed [DW-1:0]  diff_q;
  logic signed [XW-1:0]  cross_q;
  logic                  esc_q;

  logic [ZW-1:0]        mag_r, mag_i;
  logic [PW-1:0]        sq_r, sq_i, p_ri;
  logic                 done_rr, done_ii, done_ri;
  logic [PW:0]          sq_sum;
  logic [XW-1:0]        mag2;
  logic signed [DW-1:0] dsh;
  logic signed [XW-1:0] xsh;

  // Register file: unknown indexes drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_edge_q <= mbt_pkg::LEFT_EDGE_RST;
      top_edge_q  <= mbt_pkg::TOP_EDGE_RST;
      step_x_q    <= mbt_pkg::STEP_X_RST;
      step_y_q    <= mbt_pkg::STEP_Y_RST;
      max_iter_q  <= ITER_BITS'(mbt_pkg::MAX_ITER_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mbt_pkg::CFG_LEFT_EDGE: left_edge_q <= cfg_data_i;
        mbt_pkg::CFG_TOP_EDGE:  top_edge_q  <= cfg_data_i;
        mbt_pkg::CFG_STEP_X:    step_x_q    <= cfg_data_i[mbt_pkg::STEP_W-1:0];
        mbt_pkg::CFG_STEP_Y:    step_y_q    <= cfg_data_i[mbt_pkg::STEP_W-1:0];
        mbt_pkg::CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign mag_r = zr_q[ZW-1] ? -zr_q : zr_q;
  assign mag_i = zi_q[ZW-1] ? -zi_q : zi_q;

  mbt_mul #(.MW(MW)) u_mul_rr (
    .clk_i (clk_i), .rst_ni (rst_ni), .go_i (cmd_i.mul_go),
    .a_i (mag_r[MW-1:0]), .b_i (mag_r[MW-1:0]), .done_o (done_rr), .p_o (sq_r)
  );

  mbt_mul #(.MW(MW)) u_mul_ii (
    .clk_i (clk_i), .rst_ni (rst_ni), .go_i (cmd_i.mul_go),
    .a_i (mag_i[MW-1:0]), .b_i (mag_i[MW-1:0]), .done_o (done_ii), .p_o (sq_i)
  );

  mbt_mul #(.MW(MW)) u_mul_ri (
    .clk_i (clk_i), .rst_ni (rst_ni), .go_i (cmd_i.mul_go),
    .a_i (mag_r[MW-1:0]), .b_i (mag_i[MW-1:0]), .done_o (done_ri), .p_o (p_ri)
  );

  assign sq_sum = {1'b0, sq_r} + {1'b0, sq_i};
  assign mag2   = {1'b0, p_ri, 1'b0};
  assign dsh    = diff_q >>> FRAC_BITS;
  assign xsh    = cross_q >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      esc_q <= 1'b0;
    end else begin
      if (cmd_i.init_c) begin
        n_q <= '0;
      end else if (cmd_i.update) begin
        n_q <= n_q + 1'b1;
      end
      if (cmd_i.sum) begin
        esc_q <= sq_sum[PW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cprod_r_q <= PROD_W'(column_i) * PROD_W'(step_x_q);
      cprod_i_q <= PROD_W'(row_i) * PROD_W'(step_y_q);
    end
    if (cmd_i.init_c) begin
      cr_q <= CCW'(left_edge_q) + CCW'($signed({1'b0, cprod_r_q}));
      ci_q <= CCW'(top_edge_q) + CCW'($signed({1'b0, cprod_i_q}));
      zr_q <= '0;
      zi_q <= '0;
    end else if (cmd_i.update) begin
      // floor division by the scale comes from the arithmetic shift
      zr_q <= ZW'(dsh) + ZW'(cr_q);
      zi_q <= ZW'(xsh) + ZW'(ci_q);
    end
    if (cmd_i.sum) begin
      diff_q  <= $signed({1'b0, sq_r}) - $signed({1'b0, sq_i});
      cross_q <= (zr_q[ZW-1] ^ zi_q[ZW-1]) ? -$signed(mag2) : $signed(mag2);
    end
  end

  assign stat_o.limit_hit = (n_q >= max_iter_q);
  assign stat_o.too_big   = (|mag_r[ZW-1:MW]) || (|mag_i[ZW-1:MW]);
  assign stat_o.mul_done  = done_rr && done_ii && done_ri;
  assign stat_o.escaped   = esc_q;
  assign count_o          = n_q;

`ifndef ASSERT_OFF
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> n_q == $past(n_q) + 1'b1)
    else $error("iteration count did not advance by one");

  a_mul_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_go |-> !stat_o.too_big && !stat_o.limit_hit)
    else $error("multiply started on an escaped point or past the limit");
`endif

endmodule

`default_nettype wire

// ----- sv/mbt_ctrl.sv -----
`default_nettype none

module mbt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  output logic                done_o,
  input  wire mbt_pkg::stat_t stat_i,
  output mbt_pkg::cmd_t       cmd_o
);

  mbt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbt_pkg::ST_IDLE: begin
        if (start) state_d = mbt_pkg::ST_CINIT;
      end
      mbt_pkg::ST_CINIT: state_d = mbt_pkg::ST_CHECK;
      mbt_pkg::ST_CHECK: begin
        if (stat_i.limit_hit || stat_i.too_big) state_d = mbt_pkg::ST_DONE;
        else                                    state_d = mbt_pkg::ST_MUL;
      end
      mbt_pkg::ST_MUL: begin
        if (stat_i.mul_done) state_d = mbt_pkg::ST_SUM;
      end
      mbt_pkg::ST_SUM: state_d = mbt_pkg::ST_UPDATE;
      mbt_pkg::ST_UPDATE: begin
        if (stat_i.escaped) state_d = mbt_pkg::ST_DONE;
        else                state_d = mbt_pkg::ST_CHECK;
      end
      mbt_pkg::ST_DONE: state_d = mbt_pkg::ST_IDLE;
      default: state_d = mbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      mbt_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      mbt_pkg::ST_CINIT: cmd_o.init_c = 1'b1;
      mbt_pkg::ST_CHECK: cmd_o.mul_go = !(stat_i.limit_hit || stat_i.too_big);
      mbt_pkg::ST_MUL:   ;
      mbt_pkg::ST_SUM:   cmd_o.sum = 1'b1;
      mbt_pkg::ST_UPDATE: cmd_o.update = !stat_i.escaped;
      mbt_pkg::ST_DONE:  done_o = 1'b1;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("result strobe not followed by idle");
`endif

endmodule

`default_nettype wire

// ----- sv/mandelbrot_escape_time.sv -----
// done_o pulses once the iteration loop for the pixel ends; with FRAC_BITS above 31
//   the multipliers split each operand into more than one chunk.
// Throughput: one pixel at a time; the iteration loop (check, multiply, sum, update)
//   and its registered chunked multipliers set the rate.
// Reset: rst_ni clears the controller to idle and loads the register defaults.
// The result is shown for one cycle on done_o; the receiver cannot stall it.
`default_nettype none

module mandelbrot_escape_time #(
  parameter int COORD_BITS = mbt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mbt_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS  = mbt_pkg::ITER_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // pixel transaction
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [COORD_BITS-1:0]          column_i,
  input  wire logic [COORD_BITS-1:0]          row_i,
  // result strobe
  output logic                                done_o,
  output logic [ITER_BITS-1:0]                escape_count_o,
  // register write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mbt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mbt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mbt_pkg::cmd_t  cmd;
  mbt_pkg::stat_t stat;

  // Writes are always taken; the user must keep software writes only while idle, as the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // Controller: walks each pixel through c setup, then the iteration loop
  mbt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Datapath: register file, point setup, three chunked squarers/multipliers,
  // exact escape test and the z update
  mbt_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .column_i    (column_i),
    .row_i       (row_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .count_o     (escape_count_o)
  );

endmodule

`default_nettype wire
